// ----- rtl/skmap_pkg.sv -----
`default_nettype none

package skmap_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int ENTRY_W = KEY_W + VALUE_W;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_INSERTED  = 2'd1;
    localparam logic [1:0] ST_DUPLICATE = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic               operation;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] given_value;
        logic               is_dir;
    } t_in_item;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         status;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;       // capture the item and start the search
        logic       probe_rd;   // read the middle entry of the search window
        logic       probe_step; // narrow the search window
        logic       pos_rd;     // read the entry at the found position
        logic       shift_init; // start the shift pointer at the entry count
        logic       shift_rd;   // read the entry below the shift pointer
        logic       shift_wr;   // move that entry up by one place
        logic       insert;     // write the new pair and bump the count
        logic       load_out;   // load the result register
        logic [1:0] res_status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic n_zero;
        logic present;
        logic full;
        logic at_pos;
        logic is_add;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/skmap_ram.sv -----
`default_nettype none

module skmap_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/skmap_dp.sv -----
`default_nettype none

module skmap_dp
    import skmap_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_item  i_in_data,
    input  wire t_cmd      i_cmd,
    output t_sts           o_sts,
    output t_out_item      o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic               r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_gv;
    logic               r_dir;
    logic [CW-1:0]      r_lo;
    logic [CW-1:0]      r_n;
    logic [CW-1:0]      r_ptr;
    logic [CW-1:0]      r_count;
    t_out_item          r_out;

    logic [CW-1:0]      half;
    logic [CW-1:0]      probe_addr;
    logic [CW-1:0]      below_ptr;
    logic [ENTRY_W-1:0] rd_data;
    logic [KEY_W-1:0]   rd_key;
    logic [VALUE_W-1:0] rd_value;
    logic [VALUE_W-1:0] new_value;
    logic [VALUE_W-1:0] ins_value;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    assign half       = r_n >> 1;
    assign probe_addr = r_lo + half;
    assign below_ptr  = r_ptr - CW'(1);
    assign rd_key     = rd_data[ENTRY_W-1:VALUE_W];
    assign rd_value   = rd_data[VALUE_W-1:0];
    // The count is below the depth whenever a value is assigned, so it fits in 31 bits.
    assign new_value  = {r_dir, (VALUE_W - 1)'(r_count)};
    assign ins_value  = (r_op == OP_ADD) ? r_gv : new_value;

    always_comb begin
        rd_en   = i_cmd.probe_rd | i_cmd.pos_rd | i_cmd.shift_rd;
        rd_addr = r_lo[AW-1:0];
        if (i_cmd.probe_rd) begin
            rd_addr = probe_addr[AW-1:0];
        end else if (i_cmd.shift_rd) begin
            rd_addr = below_ptr[AW-1:0];
        end
    end

    always_comb begin
        wr_en   = i_cmd.shift_wr | i_cmd.insert;
        wr_addr = r_lo[AW-1:0];
        wr_data = {r_key, ins_value};
        if (i_cmd.shift_wr) begin
            wr_addr = r_ptr[AW-1:0];
            wr_data = rd_data;
        end
    end

    skmap_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.insert) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_in_data.operation;
            r_key <= i_in_data.key;
            r_gv  <= i_in_data.given_value;
            r_dir <= i_in_data.is_dir;
            r_lo  <= '0;
            r_n   <= r_count;
        end else if (i_cmd.probe_step) begin
            if (rd_key < r_key) begin
                r_lo <= r_lo + half + CW'(1);
                r_n  <= r_n - half - CW'(1);
            end else begin
                r_n  <= half;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift_init) begin
            r_ptr <= r_count;
        end else if (i_cmd.shift_wr) begin
            r_ptr <= below_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.status <= i_cmd.res_status;
            case (i_cmd.res_status)
                ST_FOUND:    r_out.value <= rd_value;
                ST_INSERTED: r_out.value <= ins_value;
                default:     r_out.value <= '0;
            endcase
        end
    end

    assign o_sts.n_zero  = (r_n == '0);
    assign o_sts.present = (r_lo < r_count) && (rd_key == r_key);
    assign o_sts.full    = (r_count == CW'(DEPTH));
    assign o_sts.at_pos  = (r_ptr == r_lo);
    assign o_sts.is_add  = (r_op == OP_ADD);
    assign o_out_data    = r_out;

endmodule

`default_nettype wire

// ----- rtl/skmap_ctrl.sv -----
`default_nettype none

module skmap_ctrl
    import skmap_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_PROBE    = 7'b0000010,
        S_STEP     = 7'b0000100,
        S_CHECK    = 7'b0001000,
        S_SHIFT    = 7'b0010000,
        S_SHIFT_WR = 7'b0100000,
        S_INSERT   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PROBE;
                end
            end
            S_PROBE: begin
                if (i_sts.n_zero) begin
                    o_cmd.pos_rd = 1'b1;
                    n_state      = S_CHECK;
                end else begin
                    o_cmd.probe_rd = 1'b1;
                    n_state        = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.probe_step = 1'b1;
                n_state          = S_PROBE;
            end
            S_CHECK: begin
                // The read data holds while the result register is still occupied.
                if (i_sts.present) begin
                    if (out_free) begin
                        o_cmd.load_out   = 1'b1;
                        o_cmd.res_status = i_sts.is_add ? ST_DUPLICATE : ST_FOUND;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.full) begin
                    if (out_free) begin
                        o_cmd.load_out   = 1'b1;
                        o_cmd.res_status = ST_FULL;
                        n_state          = S_IDLE;
                    end
                end else begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT;
                end
            end
            S_SHIFT: begin
                if (i_sts.at_pos) begin
                    n_state = S_INSERT;
                end else begin
                    o_cmd.shift_rd = 1'b1;
                    n_state        = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = S_SHIFT;
            end
            S_INSERT: begin
                if (out_free) begin
                    o_cmd.insert     = 1'b1;
                    o_cmd.load_out   = 1'b1;
                    o_cmd.res_status = ST_INSERTED;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = (r_out_valid && i_out_stall) || o_cmd.load_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/sorted_key_map_lookup_or_assign.sv -----
`default_nettype none

// Sorted key map with lookup-or-assign.
// Input channel: i_in_valid / o_in_stall with payload i_in_data. An add item
// (operation 0) inserts key and given_value at the sorted place; a lookup item
// (operation 1) returns the stored value or assigns is_dir * 2^31 + count.
// Output channel: o_out_valid / i_out_stall with payload o_out_data, one result
// per item: status found, inserted, duplicate or full.
// One item is handled at a time. A search takes at most ceil(log2(count + 1))
// binary search steps; an insert then moves every entry above the insert
// position up by one place. The next item can be accepted in the cycle after
// the result is loaded. The entry memory has a registered read, so each
// search probe is a read and then a compare, and each entry moved is a read
// and then a write.
// Reset empties the map; the memory is not cleared.
// A stalled result holds in the output register; the block finishes the
// next item up to its result and waits there until the register is taken.

module sorted_key_map_lookup_or_assign
    import skmap_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);

    t_cmd cmd;
    t_sts sts;

    skmap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    skmap_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_data (i_in_data),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_out_data(o_out_data)
    );

endmodule

`default_nettype wire
